// ===== rtl/mbt_pkg.sv =====
// Shared types, constants and size helpers for the macroblock-tiled to planar
// YUV 4:2:0 address generator. No dependencies.
package mbt_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam int unsigned DIM_W   = 13;  // picture size and register width
	localparam int unsigned ADDR_W  = 25;
	localparam int unsigned BLK_W   = 8;   // macroblock row and column counters
	localparam int unsigned MBS_W   = 9;   // macroblock count per row or column
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W  = $clog2(QUEUE_DEPTH);

	localparam logic       PLANE_LUMA   = 1'b0;
	localparam logic       PLANE_CHROMA = 1'b1;
	localparam logic       REG_WIDTH    = 1'b0;
	localparam logic       REG_HEIGHT   = 1'b1;

	localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(352);
	localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(288);

	// Rounded picture size as seen by the address datapath.
	typedef struct packed {
		logic [DIM_W-1:0] wa;
		logic [DIM_W-1:0] ha;
	} sizes_t;

	// One classified item between the front and the back.
	typedef struct packed {
		logic             plane;
		logic [7:0]       pixel;
		logic [7:0]       index;   // position inside the macroblock
		logic [BLK_W-1:0] col;
		logic [BLK_W-1:0] row;
		logic             last;
	} qentry_t;

	// Clamp to 1..limit, then round up to a multiple of 16.
	function automatic logic [DIM_W-1:0] align16(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] c;
		logic [DIM_W:0]   r;
		begin
			c = v;
			if (c == '0) begin
				c = DIM_W'(1);
			end
			if (c > limit) begin
				c = limit;
			end
			r = {1'b0, c} + (DIM_W+1)'(15);
			align16 = {r[DIM_W-1:4], 4'b0000};
		end
	endfunction

endpackage

// ===== rtl/macroblock_tile_to_planar_yuv_core.sv =====
// Top level of the macroblock-tiled to planar YUV 4:2:0 address generator.
// Instantiates mbt_front, mbt_queue and mbt_back; uses mbt_pkg.
//
// Takes one luma or chroma tile byte per item (tuser selects the stream) and
// returns one item per byte with its offset in a planar Y, U, V frame, tlast
// marking the final byte of that stream's frame. The block sustains one item
// per clock while the output is not stalled; an accepted item passes through
// the four-entry queue, then the line-times-pitch multiply stage and the final
// address add stage. Writing either size register restarts both streams at the
// top of a frame; sizes are clamped to 1..4096 and rounded up to a multiple
// of 16.
module macroblock_tile_to_planar_yuv_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [mbt_pkg::DIM_W-1:0] cfg_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [7:0]                s_axis_tdata,  // [7:0] pixel_byte
	input  logic                      s_axis_tuser,  // [0] source_plane
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [39:0]               m_axis_tdata,  // [24:0] dest_address, [32:25] pixel_out
	output logic                      m_axis_tlast   // plane_last
);
	import mbt_pkg::*;

	logic              accept, q_full, q_nonempty, q_pop;
	qentry_t           front_entry, q_head;
	sizes_t            sizes;
	logic [ADDR_W-1:0] out_addr;
	logic [7:0]        out_pixel;

	assign s_axis_tready = !q_full;
	assign accept = s_axis_tvalid && !q_full;

	mbt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.plane     (s_axis_tuser),
		.pixel     (s_axis_tdata),
		.entry     (front_entry),
		.sizes     (sizes)
	);

	mbt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	mbt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sizes     (sizes),
		.in_valid  (q_nonempty),
		.in_entry  (q_head),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_addr  (out_addr),
		.out_pixel (out_pixel),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'b0, out_pixel, out_addr};

endmodule

// ===== rtl/mbt_front.sv =====
// Front end: holds the size registers and the per-stream position counters,
// and tags each accepted item with its macroblock position. Uses mbt_pkg.
module mbt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [mbt_pkg::DIM_W-1:0] cfg_data,
	input  logic                      accept,
	input  logic                      plane,
	input  logic [7:0]                pixel,
	output mbt_pkg::qentry_t          entry,
	output mbt_pkg::sizes_t           sizes
);
	import mbt_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [7:0]       luma_idx_q;
	logic [BLK_W-1:0] luma_col_q, luma_row_q;
	logic [6:0]       chroma_idx_q;
	logic [BLK_W-1:0] chroma_col_q, chroma_row_q;

	logic [MBS_W-1:0] mbs_w, mbs_h;
	logic luma_blk_end, luma_col_end, luma_row_end;
	logic chroma_blk_end, chroma_col_end, chroma_row_end;

	always_comb begin
		sizes.wa = align16(width_q, DIM_W'(MAX_WIDTH));
		sizes.ha = align16(height_q, DIM_W'(MAX_HEIGHT));
		mbs_w = sizes.wa[DIM_W-1:4];
		mbs_h = sizes.ha[DIM_W-1:4];

		luma_blk_end   = (luma_idx_q == 8'hFF);
		luma_col_end   = ({1'b0, luma_col_q} + MBS_W'(1)) >= mbs_w;
		luma_row_end   = ({1'b0, luma_row_q} + MBS_W'(1)) >= mbs_h;
		chroma_blk_end = (chroma_idx_q == 7'h7F);
		chroma_col_end = ({1'b0, chroma_col_q} + MBS_W'(1)) >= mbs_w;
		chroma_row_end = ({1'b0, chroma_row_q} + MBS_W'(1)) >= mbs_h;

		entry.plane = plane;
		entry.pixel = pixel;
		if (plane == PLANE_LUMA) begin
			entry.index = luma_idx_q;
			entry.col   = luma_col_q;
			entry.row   = luma_row_q;
			entry.last  = luma_blk_end & luma_col_end & luma_row_end;
		end else begin
			entry.index = {1'b0, chroma_idx_q};
			entry.col   = chroma_col_q;
			entry.row   = chroma_row_q;
			entry.last  = chroma_blk_end & chroma_col_end & chroma_row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= RESET_WIDTH;
			height_q     <= RESET_HEIGHT;
			luma_idx_q   <= '0;
			luma_col_q   <= '0;
			luma_row_q   <= '0;
			chroma_idx_q <= '0;
			chroma_col_q <= '0;
			chroma_row_q <= '0;
		end else if (cfg_we) begin
			// Any size change restarts both streams at the top of the frame.
			if (cfg_index == REG_WIDTH) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
			luma_idx_q   <= '0;
			luma_col_q   <= '0;
			luma_row_q   <= '0;
			chroma_idx_q <= '0;
			chroma_col_q <= '0;
			chroma_row_q <= '0;
		end else if (accept) begin
			if (plane == PLANE_LUMA) begin
				luma_idx_q <= luma_idx_q + 8'd1;
				if (luma_blk_end) begin
					if (luma_col_end) begin
						luma_col_q <= '0;
						luma_row_q <= luma_row_end ? '0 : luma_row_q + BLK_W'(1);
					end else begin
						luma_col_q <= luma_col_q + BLK_W'(1);
					end
				end
			end else begin
				chroma_idx_q <= chroma_idx_q + 7'd1;
				if (chroma_blk_end) begin
					if (chroma_col_end) begin
						chroma_col_q <= '0;
						chroma_row_q <= chroma_row_end ? '0 : chroma_row_q + BLK_W'(1);
					end else begin
						chroma_col_q <= chroma_col_q + BLK_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== rtl/mbt_queue.sv =====
// Short queue of classified items between the front and the back.
// Uses mbt_pkg.
module mbt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbt_pkg::qentry_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output mbt_pkg::qentry_t head
);
	import mbt_pkg::*;

	qentry_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/mbt_back.sv =====
// Back end: two-stage address datapath (line multiply, then final add) with a
// stall-able output register. Uses mbt_pkg.
module mbt_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mbt_pkg::sizes_t            sizes,
	input  logic                       in_valid,
	input  mbt_pkg::qentry_t           in_entry,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mbt_pkg::ADDR_W-1:0] out_addr,
	output logic [7:0]                 out_pixel,
	output logic                       out_last
);
	import mbt_pkg::*;

	logic [ADDR_W-1:0] ysize_q;
	logic [ADDR_W-1:0] ysize_full;

	logic              valid_s1, valid_s2;
	logic [ADDR_W-1:0] prod_s1, base_s1;
	logic [11:0]       offs_s1;
	logic [7:0]        pixel_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s2;
	logic [7:0]        pixel_s2;
	logic              last_s2;

	logic              en1, en2;
	logic [11:0]       line;
	logic [DIM_W-1:0]  pitch;
	logic [11:0]       offs;
	logic [ADDR_W-1:0] base;
	logic [DIM_W+11:0] prod;

	assign en2 = !valid_s2 || out_ready;
	assign en1 = !valid_s1 || en2;
	assign pop = in_valid && en1;

	// The largest frame is 4096 by 4096, so the luma size always fits the address width.
	assign ysize_full = ADDR_W'(sizes.wa) * ADDR_W'(sizes.ha);

	always_comb begin
		if (in_entry.plane == PLANE_LUMA) begin
			// Quadrant bits: index[7] picks the lower half, index[6] the right half.
			line  = {in_entry.row, in_entry.index[7], in_entry.index[5:3]};
			pitch = sizes.wa;
			offs  = {in_entry.col, in_entry.index[6], in_entry.index[2:0]};
			base  = '0;
		end else begin
			line  = {1'b0, in_entry.row, in_entry.index[5:3]};
			pitch = {1'b0, sizes.wa[DIM_W-1:1]};
			offs  = {1'b0, in_entry.col, in_entry.index[2:0]};
			// Second half of the chroma block goes to the V plane.
			base  = in_entry.index[6] ? ysize_q + (ysize_q >> 2) : ysize_q;
		end
		prod = (DIM_W+12)'(line) * (DIM_W+12)'(pitch);
	end

	always_ff @(posedge clk) begin
		ysize_q <= ysize_full;
		if (en1) begin
			prod_s1  <= prod[ADDR_W-1:0];
			base_s1  <= base;
			offs_s1  <= offs;
			pixel_s1 <= in_entry.pixel;
			last_s1  <= in_entry.last;
		end
		if (en2) begin
			addr_s2  <= prod_s1 + base_s1 + ADDR_W'(offs_s1);
			pixel_s2 <= pixel_s1;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign out_addr  = addr_s2;
	assign out_pixel = pixel_s2;
	assign out_last  = last_s2;

endmodule
